/* hdl/pcc_pkg.sv */
`default_nettype none

package pcc_pkg;

    // Configuration register layout
    localparam int CFG_BITS = 6;
    localparam logic REG_MOTIF_LENGTH  = 1'b0;
    localparam logic REG_ALPHABET_SIZE = 1'b1;
    localparam logic [CFG_BITS-1:0] MOTIF_LENGTH_RST  = 6'd8;
    localparam logic [CFG_BITS-1:0] ALPHABET_SIZE_RST = 6'd4;

    // Field widths
    localparam int SYM_BITS = 5;
    localparam int COL_BITS = 5;
    localparam int TOP_BITS = 16;
    // Effective length needs room for the largest column count
    localparam int LEN_BITS = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_SWEEP,
        ST_FLUSH
    } pcc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle, count it
        logic issue;    // sweep step: clear one entry, advance the sweep address
        logic emit;     // sweep step also reads the entry for a consensus result
    } pcc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;  // sweep address at its final entry
        logic hold;        // result waits on a full output register
        logic sw_busy;     // a sweep read is still in the compare stage
    } pcc_status_t;

endpackage

`default_nettype wire

/* hdl/pcc_regs.sv */
`default_nettype none

module pcc_regs
    import pcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic [CFG_BITS-1:0]      motif_length,
    output logic [CFG_BITS-1:0]      alphabet_size
);

    logic [CFG_BITS-1:0] motif_length_reg;
    logic [CFG_BITS-1:0] alphabet_size_reg;
    logic                wr_en;

    // pready is tied high, so the access cycle completes the write
    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_length_reg  <= MOTIF_LENGTH_RST;
            alphabet_size_reg <= ALPHABET_SIZE_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MOTIF_LENGTH:  motif_length_reg  <= pwdata[CFG_BITS-1:0];
                REG_ALPHABET_SIZE: alphabet_size_reg <= pwdata[CFG_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[2])
            REG_MOTIF_LENGTH:  prdata = {{(32-CFG_BITS){1'b0}}, motif_length_reg};
            REG_ALPHABET_SIZE: prdata = {{(32-CFG_BITS){1'b0}}, alphabet_size_reg};
            default:           prdata = '0;
        endcase
    end

    assign motif_length  = motif_length_reg;
    assign alphabet_size = alphabet_size_reg;

endmodule

`default_nettype wire

/* hdl/pcc_ctrl.sv */
`default_nettype none

module pcc_ctrl
    import pcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_last,
    output logic             in_ready,
    input  wire pcc_status_t status,
    output pcc_cmd_t         cmd
);

    pcc_state_t state_reg;
    pcc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (status.sweep_last)
                    state_next = ST_RUN;
            ST_RUN:
                if (in_valid && in_last)
                    state_next = ST_DRAIN;
            // let the final symbol's write land before the sweep reads
            ST_DRAIN:
                state_next = ST_SWEEP;
            ST_SWEEP:
                if (!status.hold && status.sweep_last)
                    state_next = ST_FLUSH;
            ST_FLUSH:
                if (!status.sw_busy)
                    state_next = ST_RUN;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.issue  = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
                cmd.issue = 1'b1;
            ST_RUN:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SWEEP:
            begin
                cmd.issue = !status.hold;
                cmd.emit  = 1'b1;
            end
            ST_DRAIN, ST_FLUSH:
                ;
            default:
                ;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/pcc_dp.sv */
`default_nettype none

module pcc_dp
    import pcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_SYMBOLS = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pcc_cmd_t            cmd,
    output pcc_status_t              status,
    input  wire logic [CFG_BITS-1:0] motif_length,
    input  wire logic [CFG_BITS-1:0] alphabet_size,
    input  wire logic [SYM_BITS-1:0] site_symbol,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [COL_BITS-1:0]      column_index,
    output logic [SYM_BITS-1:0]      consensus_symbol,
    output logic [TOP_BITS-1:0]      top_count,
    output logic                     last_column
);

    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SW    = $clog2(MAX_SYMBOLS);
    localparam int AW    = CW + SW;
    localparam int DEPTH = 1 << AW;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Effective configuration
    logic [LEN_BITS-1:0] len_eff;
    logic [CFG_BITS-1:0] asize_eff;

    always_comb
    begin
        priority if (motif_length == '0)
            len_eff = LEN_BITS'(1);
        else if (LEN_BITS'(motif_length) > LEN_BITS'(MAX_COLUMNS))
            len_eff = LEN_BITS'(MAX_COLUMNS);
        else
            len_eff = LEN_BITS'(motif_length);
    end

    assign asize_eff = (alphabet_size > CFG_BITS'(MAX_SYMBOLS)) ?
                       CFG_BITS'(MAX_SYMBOLS) : alphabet_size;

    // Column position
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [CW-1:0]       col_eff;
    logic [LEN_BITS-1:0] col_inc;
    logic [CW-1:0]       col_adv;

    assign col_eff = (LEN_BITS'(col_reg) >= len_eff) ? '0 : col_reg;
    assign col_inc = LEN_BITS'(col_eff) + LEN_BITS'(1);
    assign col_adv = (col_inc >= len_eff) ? '0 : col_inc[CW-1:0];

    always_comb
    begin
        priority if (cmd.accept)
            col_next = col_adv;
        else if (cmd.issue)
            col_next = '0;
        else
            col_next = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else
            col_reg <= col_next;
    end

    // Input decode
    logic          sym_ok;
    logic [AW-1:0] addr_in;

    assign sym_ok  = (CFG_BITS'(site_symbol) < asize_eff);
    assign addr_in = {col_eff, site_symbol[SW-1:0]};

    // Sweep address: column in the upper bits, symbol in the lower bits
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;

    assign sweep_next = cmd.issue ? sweep_reg + AW'(1) : sweep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else
            sweep_reg <= sweep_next;
    end

    // Compare stage registers
    logic                  s2_cnt_valid_reg;
    logic [AW-1:0]         s2_cnt_addr_reg;
    logic                  s2_sw_valid_reg;
    logic                  s2_sw_valid_next;
    logic [AW-1:0]         s2_sw_addr_reg;
    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic                  hold;

    // Count memory, read data registered, read returns the old word
    logic [COUNT_BITS-1:0] count_mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign mem_re    = cmd.accept || (cmd.issue && cmd.emit);
    assign mem_raddr = cmd.accept ? addr_in : sweep_reg;

    // Increment with forwarding from the write of the previous cycle
    assign cnt_cur = (fwd_valid_reg && (fwd_addr_reg == s2_cnt_addr_reg)) ?
                     fwd_data_reg : rd_data_reg;
    assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = '0;
        priority if (s2_cnt_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = s2_cnt_addr_reg;
            mem_wdata = cnt_inc;
        end
        else if (cmd.issue)
            mem_we = 1'b1;
        else
            mem_we = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            count_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= count_mem[mem_raddr];
    end

    // Stage control
    assign s2_sw_valid_next = hold ? 1'b1 : (cmd.issue && cmd.emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_cnt_valid_reg <= 1'b0;
            s2_sw_valid_reg  <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            s2_cnt_valid_reg <= cmd.accept && sym_ok;
            s2_sw_valid_reg  <= s2_sw_valid_next;
            fwd_valid_reg    <= s2_cnt_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cnt_addr_reg <= addr_in;
        fwd_addr_reg    <= s2_cnt_addr_reg;
        fwd_data_reg    <= cnt_inc;
        if (!hold)
            s2_sw_addr_reg <= sweep_reg;
    end

    // Running maximum over one column
    logic [CW-1:0]         sw_col;
    logic [SW-1:0]         sw_sym;
    logic [COUNT_BITS-1:0] best_reg;
    logic [COUNT_BITS-1:0] best_next;
    logic [COUNT_BITS-1:0] best_base;
    logic [SW-1:0]         bsym_reg;
    logic [SW-1:0]         bsym_next;
    logic [SW-1:0]         bsym_base;
    logic                  take;
    logic                  col_end;
    logic                  col_emit;

    assign sw_col    = s2_sw_addr_reg[AW-1:SW];
    assign sw_sym    = s2_sw_addr_reg[SW-1:0];
    assign best_base = (sw_sym == '0) ? '0 : best_reg;
    assign bsym_base = (sw_sym == '0) ? '0 : bsym_reg;
    assign take      = (CFG_BITS'(sw_sym) < asize_eff) && (rd_data_reg > best_base);
    assign best_next = take ? rd_data_reg : best_base;
    assign bsym_next = take ? sw_sym : bsym_base;
    assign col_end   = &sw_sym;
    assign col_emit  = s2_sw_valid_reg && col_end && (LEN_BITS'(sw_col) < len_eff);
    assign hold      = col_emit && out_valid && !out_ready;

    always_ff @(posedge clk)
    begin
        if (s2_sw_valid_reg && !hold)
        begin
            best_reg <= best_next;
            bsym_reg <= bsym_next;
        end
    end

    // Output register
    logic                out_valid_reg;
    logic [COL_BITS-1:0] col_out_reg;
    logic [SYM_BITS-1:0] sym_out_reg;
    logic [TOP_BITS-1:0] top_out_reg;
    logic                last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (col_emit && !hold)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (col_emit && !hold)
        begin
            col_out_reg  <= COL_BITS'(sw_col);
            sym_out_reg  <= SYM_BITS'(bsym_next);
            top_out_reg  <= TOP_BITS'(best_next);
            last_out_reg <= (LEN_BITS'(sw_col) + LEN_BITS'(1) == len_eff);
        end
    end

    assign out_valid        = out_valid_reg;
    assign column_index     = col_out_reg;
    assign consensus_symbol = sym_out_reg;
    assign top_count        = top_out_reg;
    assign last_column      = last_out_reg;

    assign status.sweep_last = &sweep_reg;
    assign status.hold       = hold;
    assign status.sw_busy    = s2_sw_valid_reg;

    // Checks
    a_stage_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s2_cnt_valid_reg && s2_sw_valid_reg))
        else $error("count and sweep both in compare stage");

    a_hold_keeps_entry: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> s2_sw_valid_reg && $stable(s2_sw_addr_reg) && out_valid_reg)
        else $error("held sweep entry lost");

    a_no_count_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !s2_sw_valid_reg && !cmd.issue)
        else $error("symbol accepted during sweep");

    a_hold_blocks_issue: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> !cmd.issue)
        else $error("sweep advanced while result held");

endmodule

`default_nettype wire

/* hdl/position_count_consensus.sv */
`default_nettype none

// Position count consensus. Site symbols stream in on s_axis, one per transfer, in
// row order; an internal column counter wraps at motif_length. Each symbol below
// alphabet_size bumps a saturating count for its (symbol, column) pair. A transfer
// with tlast high is counted and then triggers one m_axis result per column: the
// column, the symbol with the highest count (lowest index on ties, 0 for an empty
// column), that count's low 16 bits, and tlast on the final column. The count table
// and column counter are then cleared. Rate: one symbol per cycle while counting,
// set by the read-modify-write of the count memory (one read and one write port)
// with forwarding.
// After a final transfer the emission sweep reads and clears every memory entry,
// one per cycle while the output does not stall.
// After reset a clearing pass over every memory entry runs before the first symbol
// is taken. Registers on APB: motif_length at 0x0, alphabet_size at 0x4; write them
// only while the block is idle.
module position_count_consensus
    import pcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_SYMBOLS = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [4:0] site_symbol, [7:5] zero
    input  wire logic        s_axis_tlast,   // final_item
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [4:0] column_index, [9:5] consensus_symbol,
                                             // [25:10] top_count, [31:26] zero
    output logic             m_axis_tlast    // last_column
);

    logic [CFG_BITS-1:0] motif_length;
    logic [CFG_BITS-1:0] alphabet_size;
    pcc_cmd_t            cmd;
    pcc_status_t         status;
    logic [COL_BITS-1:0] column_index;
    logic [SYM_BITS-1:0] consensus_symbol;
    logic [TOP_BITS-1:0] top_count;

    assign pready = 1'b1;

    pcc_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .motif_length  (motif_length),
        .alphabet_size (alphabet_size)
    );

    pcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcc_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .motif_length     (motif_length),
        .alphabet_size    (alphabet_size),
        .site_symbol      (s_axis_tdata[SYM_BITS-1:0]),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .column_index     (column_index),
        .consensus_symbol (consensus_symbol),
        .top_count        (top_count),
        .last_column      (m_axis_tlast)
    );

    // Result packing
    assign m_axis_tdata = {6'b0, top_count, consensus_symbol, column_index};

endmodule

`default_nettype wire
